// ----- rtl/fusf_pkg.sv -----
// Shared types and constants of the first unique symbol finder.
package fusf_pkg;

    localparam int ALPHABET_SIZE = 256;
    localparam int MAX_LEN       = 65536;
    localparam int SYMBOL_W      = 8;
    localparam int OUT_POS_W     = 17;
    localparam int IDX_W         = $clog2(ALPHABET_SIZE);
    localparam int POS_W         = $clog2(MAX_LEN);
    localparam int CNT_W         = $clog2(MAX_LEN + 1);

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [POS_W-1:0] t_pos;

    typedef struct packed {
        logic repeated;
        t_pos pos;
    } t_entry;

    typedef struct packed {
        logic   en;
        t_idx   addr;
        t_entry data;
    } t_wr;

    typedef struct packed {
        logic   valid;
        t_entry data;
    } t_rd;

endpackage

// ----- rtl/fusf_table.sv -----
// Symbol table: entry memory with registered read and per-entry valid bits.
module fusf_table (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_rd_en,
    input  fusf_pkg::t_idx i_rd_addr,
    input  fusf_pkg::t_wr  i_wr,
    input  logic           i_clear,
    output fusf_pkg::t_rd  o_rd
);
    import fusf_pkg::*;

    t_entry                   r_mem [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] r_valid;
    t_entry                   r_rd_data;
    logic                     r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else if (i_rd_en) begin
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd.valid = r_rd_valid;
    assign o_rd.data  = r_rd_data;

endmodule

// ----- rtl/first_unique_symbol_finder.sv -----
// First unique symbol finder: byte intake, table update and end-of-string scan.
// A non-final byte holds busy through a table read, then a write: a new byte is taken only after the last is written.
// A final byte holds busy through the update, a scan of one table entry
// a cycle through the single read port and comparator, then the result strobe.
// The strobe lasts one cycle; the receiver cannot stall it.
// Synchronous reset clears the valid bits, counter and flag at once: no clearing pass.
module first_unique_symbol_finder (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [fusf_pkg::SYMBOL_W-1:0]          i_symbol,
    input  logic                                   i_last_symbol,
    output logic                                   o_result_strobe,
    output logic signed [fusf_pkg::OUT_POS_W-1:0]  o_first_unique_position,
    output logic                                   o_length_overflow
);
    import fusf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_UPDATE = 4'b0010,
        S_SCAN   = 4'b0100,
        S_EMIT   = 4'b1000
    } t_state;

    localparam logic [IDX_W:0] SCAN_END = (IDX_W + 1)'(ALPHABET_SIZE);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_overflow, n_overflow;
    t_pos             r_pos, n_pos;
    t_idx             r_sym;
    logic             r_in_alpha, r_last;
    logic [IDX_W:0]   r_idx, n_idx;
    logic             r_pend, n_pend;
    logic             r_found, n_found;
    t_pos             r_best, n_best;

    logic rd_en;
    t_idx rd_addr;
    t_wr  wr;
    t_rd  rd;
    logic clear;
    logic accept;
    logic better;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    fusf_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_wr      (wr),
        .i_clear   (clear),
        .o_rd      (rd)
    );

    // comparator used by the scan
    assign better = rd.valid && !rd.data.repeated && (!r_found || (rd.data.pos < r_best));

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_overflow = r_overflow;
        n_pos      = r_pos;
        n_idx      = r_idx;
        n_pend     = 1'b0;
        n_found    = r_found;
        n_best     = r_best;
        rd_en      = 1'b0;
        rd_addr    = IDX_W'(i_symbol);
        wr.en      = 1'b0;
        wr.addr    = r_sym;
        wr.data    = '0;
        clear      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    rd_en = 1'b1;
                    if (r_count >= CNT_W'(MAX_LEN)) begin
                        n_overflow = 1'b1;
                        n_pos      = POS_W'(MAX_LEN - 1);
                    end else begin
                        n_pos   = POS_W'(r_count);
                        n_count = r_count + 1'b1;
                    end
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                wr.en = r_in_alpha;
                if (rd.valid) begin
                    wr.data.repeated = 1'b1;
                    wr.data.pos      = rd.data.pos;
                end else begin
                    wr.data.repeated = 1'b0;
                    wr.data.pos      = r_pos;
                end
                n_idx   = '0;
                n_found = 1'b0;
                n_state = r_last ? S_SCAN : S_IDLE;
            end
            S_SCAN: begin
                rd_addr = r_idx[IDX_W-1:0];
                if (r_idx != SCAN_END) begin
                    rd_en  = 1'b1;
                    n_pend = 1'b1;
                    n_idx  = r_idx + 1'b1;
                end else begin
                    n_state = S_EMIT;
                end
                if (r_pend && better) begin
                    n_found = 1'b1;
                    n_best  = rd.data.pos;
                end
            end
            S_EMIT: begin
                clear      = 1'b1;
                n_count    = '0;
                n_overflow = 1'b0;
                n_found    = 1'b0;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_overflow <= 1'b0;
            r_pend     <= 1'b0;
            r_found    <= 1'b0;
            r_idx      <= '0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_overflow <= n_overflow;
            r_pend     <= n_pend;
            r_found    <= n_found;
            r_idx      <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_best <= n_best;
        if (accept) begin
            r_sym      <= IDX_W'(i_symbol);
            r_in_alpha <= (int'(i_symbol) < ALPHABET_SIZE);
            r_last     <= i_last_symbol;
        end
    end

    assign o_result_strobe         = (r_state == S_EMIT);
    assign o_first_unique_position = r_found ? OUT_POS_W'(r_best) : '1;
    assign o_length_overflow       = r_overflow;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted word did not raise busy");

    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |=> (!busy && r_count == '0 && !r_overflow && !r_found))
        else $error("state not cleared after result");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_LEN))
        else $error("position counter past saturation");

    a_scan_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(r_state == S_SCAN) && $past(r_idx == SCAN_END))
        else $error("result strobe without a full scan");

endmodule
